// ===== design/teu_pkg.sv =====
// shared constants, types and helpers for the toy isa execute unit
package teu_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);

    // data memory size in bytes, a power of two
    localparam int DATA_BYTES = 4096;
    localparam int DATA_AW    = $clog2(DATA_BYTES);
    localparam int DMEM_BANKS = 4;
    localparam int DMEM_ROWS  = DATA_BYTES / DMEM_BANKS;
    localparam int ROW_AW     = DATA_AW - 2;

    localparam logic [REG_AW-1:0] LINK_INDEX      = REG_AW'(14);
    localparam logic [REG_AW-1:0] PREDICATE_INDEX = REG_AW'(15);
    localparam logic [XLEN-1:0]   INSN_BYTES      = XLEN'(4);

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_STORE = 4'd2,
        FN_LOAD  = 4'd3,
        FN_RET   = 4'd4,
        FN_CALL  = 4'd5,
        FN_MOVI  = 4'd6,
        FN_BR    = 4'd7,
        FN_BRCC  = 4'd8,
        FN_CMPLT = 4'd9,
        FN_CMPGT = 4'd10,
        FN_CMPGE = 4'd11
    } t_func;

    // everything the execute logic decides for one instruction
    typedef struct packed {
        logic [XLEN-1:0]   next_address;
        logic              reg_we;
        logic [REG_AW-1:0] target;
        logic [XLEN-1:0]   value;
        logic              mem_we;
        logic [XLEN-1:0]   store_address;
        logic              is_load;
        logic [XLEN-1:0]   daddr;
        logic [XLEN-1:0]   store_data;
    } t_exec;

    // what sits in the result register
    typedef struct packed {
        logic [XLEN-1:0]   next_address;
        logic              reg_we;
        logic [REG_AW-1:0] target;
        logic [XLEN-1:0]   value;
        logic              mem_we;
        logic [XLEN-1:0]   store_address;
        logic              is_load;
    } t_result;

    // register file write port
    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] idx;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    function automatic logic [XLEN-1:0] f_sext16(input logic [15:0] imm);
        return {{(XLEN-16){imm[15]}}, imm};
    endfunction

    // first operand: rs1 for add/sub, base or second compare source otherwise
    function automatic logic [REG_AW-1:0] f_idx_a(input t_func fn, input logic [31:0] w);
        logic [REG_AW-1:0] idx;
        idx = ((fn == FN_ADD) || (fn == FN_SUB)) ? w[19:16] : w[7:4];
        return idx;
    endfunction

endpackage

// ===== design/teu_ram.sv =====
// generic single write port ram with registered read
module teu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/teu_regfile.sv =====
// register file: three read copies, valid bits, write bypass, link and predicate shadows
module teu_regfile (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [teu_pkg::REG_AW-1:0]   i_raddr_a,
    input  logic [teu_pkg::REG_AW-1:0]   i_raddr_b,
    input  logic [teu_pkg::REG_AW-1:0]   i_raddr_c,
    input  logic [teu_pkg::REG_AW-1:0]   i_op_idx_a,
    input  logic [teu_pkg::REG_AW-1:0]   i_op_idx_b,
    input  logic [teu_pkg::REG_AW-1:0]   i_op_idx_c,
    input  teu_pkg::t_rf_wr              i_wr,
    output logic [teu_pkg::XLEN-1:0]     o_op_a,
    output logic [teu_pkg::XLEN-1:0]     o_op_b,
    output logic [teu_pkg::XLEN-1:0]     o_op_c,
    output logic [teu_pkg::XLEN-1:0]     o_link,
    output logic [teu_pkg::XLEN-1:0]     o_pred
);
    import teu_pkg::*;

    logic [REG_COUNT-1:0] r_valid;
    t_rf_wr               r_byp;
    logic [XLEN-1:0]      r_link;
    logic [XLEN-1:0]      r_pred;
    logic [XLEN-1:0]      q_a;
    logic [XLEN-1:0]      q_b;
    logic [XLEN-1:0]      q_c;

    teu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_a (
        .i_clk(i_clk), .i_we(i_wr.we), .i_waddr(i_wr.idx), .i_wdata(i_wr.data),
        .i_re(1'b1), .i_raddr(i_raddr_a), .o_rdata(q_a)
    );
    teu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_b (
        .i_clk(i_clk), .i_we(i_wr.we), .i_waddr(i_wr.idx), .i_wdata(i_wr.data),
        .i_re(1'b1), .i_raddr(i_raddr_b), .o_rdata(q_b)
    );
    teu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_c (
        .i_clk(i_clk), .i_we(i_wr.we), .i_waddr(i_wr.idx), .i_wdata(i_wr.data),
        .i_re(1'b1), .i_raddr(i_raddr_c), .o_rdata(q_c)
    );

    // newest first: write in flight, write at last edge, ram copy, reset value
    function automatic logic [XLEN-1:0] f_pick(
        input logic [REG_AW-1:0]    idx,
        input logic [XLEN-1:0]      q,
        input t_rf_wr               wr,
        input t_rf_wr               byp,
        input logic [REG_COUNT-1:0] vld
    );
        logic [XLEN-1:0] v;
        if (wr.we && (wr.idx == idx)) begin
            v = wr.data;
        end else if (byp.we && (byp.idx == idx)) begin
            v = byp.data;
        end else if (vld[idx]) begin
            v = q;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_byp   <= '0;
            r_link  <= '0;
            r_pred  <= '0;
        end else begin
            r_byp <= i_wr;
            if (i_wr.we) begin
                r_valid[i_wr.idx] <= 1'b1;
                if (i_wr.idx == LINK_INDEX) begin
                    r_link <= i_wr.data;
                end
                if (i_wr.idx == PREDICATE_INDEX) begin
                    r_pred <= i_wr.data;
                end
            end
        end
    end

    always_comb begin
        o_op_a = f_pick(i_op_idx_a, q_a, i_wr, r_byp, r_valid);
        o_op_b = f_pick(i_op_idx_b, q_b, i_wr, r_byp, r_valid);
        o_op_c = f_pick(i_op_idx_c, q_c, i_wr, r_byp, r_valid);
        o_link = (i_wr.we && (i_wr.idx == LINK_INDEX)) ? i_wr.data : r_link;
        o_pred = (i_wr.we && (i_wr.idx == PREDICATE_INDEX)) ? i_wr.data : r_pred;
    end

endmodule

// ===== design/teu_exec.sv =====
// single pass execute logic for one instruction
module teu_exec (
    input  teu_pkg::t_func               i_func,
    input  logic [31:0]                  i_word,
    input  logic [teu_pkg::XLEN-1:0]     i_pc,
    input  logic [teu_pkg::XLEN-1:0]     i_op_a,
    input  logic [teu_pkg::XLEN-1:0]     i_op_b,
    input  logic [teu_pkg::XLEN-1:0]     i_op_c,
    input  logic [teu_pkg::XLEN-1:0]     i_link,
    input  logic [teu_pkg::XLEN-1:0]     i_pred,
    output teu_pkg::t_exec               o_exec
);
    import teu_pkg::*;

    logic [XLEN-1:0] simm;
    logic [XLEN-1:0] zimm;
    logic [XLEN-1:0] pc_seq;
    logic [XLEN-1:0] pc_jump;
    logic [XLEN-1:0] daddr;
    logic            lt;
    logic            eq;

    assign simm    = f_sext16(i_word[15:0]);
    assign zimm    = {{(XLEN-16){1'b0}}, i_word[15:0]};
    assign pc_seq  = i_pc + INSN_BYTES;
    // call uses an unsigned offset, branches a signed one
    assign pc_jump = i_pc + ((i_func == FN_CALL) ? zimm : simm);
    assign daddr   = i_op_a + i_op_b;
    assign lt      = $signed(i_op_c) < $signed(i_op_a);
    assign eq      = i_op_c == i_op_a;

    always_comb begin
        o_exec              = '0;
        o_exec.next_address = pc_seq;
        o_exec.daddr        = daddr;
        o_exec.store_data   = i_op_c;
        case (i_func)
            FN_ADD: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = i_word[23:20];
                o_exec.value  = i_op_a + simm;
            end
            FN_SUB: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = i_word[23:20];
                o_exec.value  = i_op_a - simm;
            end
            FN_STORE: begin
                o_exec.mem_we        = 1'b1;
                o_exec.store_address = daddr;
            end
            FN_LOAD: begin
                o_exec.reg_we  = 1'b1;
                o_exec.target  = i_word[3:0];
                o_exec.is_load = 1'b1;
            end
            FN_RET: begin
                o_exec.next_address = i_link;
            end
            FN_CALL: begin
                o_exec.reg_we       = 1'b1;
                o_exec.target       = LINK_INDEX;
                o_exec.value        = pc_seq;
                o_exec.next_address = pc_jump;
            end
            FN_MOVI: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = i_word[23:20];
                o_exec.value  = zimm;
            end
            FN_BR: begin
                o_exec.next_address = pc_jump;
            end
            FN_BRCC: begin
                if (i_pred == XLEN'(1)) begin
                    o_exec.next_address = pc_jump;
                end
            end
            FN_CMPLT: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = PREDICATE_INDEX;
                o_exec.value  = {{(XLEN-1){1'b0}}, lt};
            end
            FN_CMPGT: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = PREDICATE_INDEX;
                o_exec.value  = {{(XLEN-1){1'b0}}, !lt && !eq};
            end
            FN_CMPGE: begin
                o_exec.reg_we = 1'b1;
                o_exec.target = PREDICATE_INDEX;
                o_exec.value  = {{(XLEN-1){1'b0}}, !lt};
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/teu_dmem.sv =====
// byte data memory in four banks with unaligned word access and reset clearing pass
module teu_dmem (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [teu_pkg::XLEN-1:0] i_addr,
    input  logic [teu_pkg::XLEN-1:0] i_wdata,
    output logic [teu_pkg::XLEN-1:0] o_rdata,
    output logic                     o_busy
);
    import teu_pkg::*;

    logic              r_busy;
    logic [ROW_AW-1:0] r_clr_row;
    logic [1:0]        r_lsb;
    logic [DATA_AW-1:0] a;
    logic [7:0]        bank_q [DMEM_BANKS];

    assign a = i_addr[DATA_AW-1:0];

    genvar j;
    generate
        for (j = 0; j < DMEM_BANKS; j++) begin : g_bank
            localparam logic [1:0] BANK = 2'(j);
            logic [1:0]         k;
            logic [DATA_AW-1:0] sum;
            logic [ROW_AW-1:0]  row;
            logic [7:0]         wbyte;

            // byte k of the word lands in this bank, each byte wraps on its own
            assign k     = BANK - a[1:0];
            assign sum   = a + DATA_AW'(k);
            assign row   = sum[DATA_AW-1:2];
            assign wbyte = 8'(i_wdata >> {k, 3'b000});

            teu_ram #(.WIDTH(8), .DEPTH(DMEM_ROWS)) u_bank (
                .i_clk  (i_clk),
                .i_we   (r_busy || i_we),
                .i_waddr(r_busy ? r_clr_row : row),
                .i_wdata(r_busy ? 8'h00 : wbyte),
                .i_re   (i_re),
                .i_raddr(row),
                .o_rdata(bank_q[j])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            r_clr_row <= r_clr_row + ROW_AW'(1);
            if (r_clr_row == ROW_AW'(DMEM_ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_lsb <= a[1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < DMEM_BANKS; k++) begin
            o_rdata[8*k +: 8] = bank_q[r_lsb + 2'(k)];
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== design/toy_isa_execute_unit.sv =====
// top level of the toy isa execute unit
// Executes one pre-classified instruction per input beat and returns one result beat
// per instruction. Throughput is one instruction per clock while result beats are
// taken, with no dependency stalls: the instruction sits in an input register, a single
// pass of execute logic reads the register file and program counter and fills the
// result register, and a new beat is taken in the same cycle a finished result is
// handed on. Register results are written back in the cycle after the result register
// is loaded and forwarded to the next instruction, so back-to-back dependent
// instructions, including a load followed by its use, run at full rate. Loads read the
// banked data memory at the edge the result register is loaded and the loaded word
// appears on the result beat. After reset the data memory is cleared by a pass over its
// DATA_BYTES/4 rows (1024 at the default size) during which no input beat is accepted;
// configuration writes are taken at any time. A start_address write loads the program
// counter at once and is only to be issued while the unit is idle.
module toy_isa_execute_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: start_address
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [teu_pkg::XLEN-1:0]         i_cfg_data,
    // instruction beats
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [teu_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // [31:0] instruction_word
    input  logic [teu_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,  // [3:0] func
    // result beats
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] next_address, [35:32] target_register, [67:36] written_value,
    // [99:68] store_address, [103:100] zero
    output logic [teu_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] register_written, [1] memory_stored
    output logic [teu_pkg::M_TUSER_W-1:0]    o_m_axis_tuser
);
    import teu_pkg::*;

    // input register
    logic        r_ex_vld;
    t_func       r_ex_func;
    logic [31:0] r_ex_word;

    // result register
    logic        r_out_vld;
    t_result     r_out;

    // write back in the cycle after the result register loads
    logic              r_wb_pend;
    logic [REG_AW-1:0] r_wb_idx;
    logic [XLEN-1:0]   r_wb_val;
    logic              r_wb_load;

    logic [XLEN-1:0] r_pc;

    logic            out_free;
    logic            commit;
    logic            s_accept;
    logic            cfg_accept;
    logic            dmem_busy;
    t_func           in_func;
    t_exec           exec;
    t_rf_wr          rf_wr;
    logic [XLEN-1:0] ld_data;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    logic [XLEN-1:0] op_c;
    logic [XLEN-1:0] link;
    logic [XLEN-1:0] pred;
    logic [XLEN-1:0] out_value;
    logic [REG_AW-1:0] raddr_a;
    logic [REG_AW-1:0] raddr_b;
    logic [REG_AW-1:0] raddr_c;

    // handshake: input register empties whenever the result register can take a beat
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign commit          = r_ex_vld && out_free;
    assign o_s_axis_tready = !dmem_busy && (!r_ex_vld || commit);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign cfg_accept      = i_cfg_valid && o_cfg_ready;
    assign in_func         = t_func'(i_s_axis_tuser);

    // register file ram addresses: the arriving beat on accept, else the held one
    always_comb begin
        if (s_accept) begin
            raddr_a = f_idx_a(in_func, i_s_axis_tdata);
            raddr_b = i_s_axis_tdata[11:8];
            raddr_c = i_s_axis_tdata[3:0];
        end else begin
            raddr_a = f_idx_a(r_ex_func, r_ex_word);
            raddr_b = r_ex_word[11:8];
            raddr_c = r_ex_word[3:0];
        end
    end

    // loaded words reach the register file straight from the data memory output
    assign rf_wr.we   = r_wb_pend;
    assign rf_wr.idx  = r_wb_idx;
    assign rf_wr.data = r_wb_load ? ld_data : r_wb_val;

    teu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .i_raddr_c (raddr_c),
        .i_op_idx_a(f_idx_a(r_ex_func, r_ex_word)),
        .i_op_idx_b(r_ex_word[11:8]),
        .i_op_idx_c(r_ex_word[3:0]),
        .i_wr      (rf_wr),
        .o_op_a    (op_a),
        .o_op_b    (op_b),
        .o_op_c    (op_c),
        .o_link    (link),
        .o_pred    (pred)
    );

    teu_exec u_exec (
        .i_func(r_ex_func),
        .i_word(r_ex_word),
        .i_pc  (r_pc),
        .i_op_a(op_a),
        .i_op_b(op_b),
        .i_op_c(op_c),
        .i_link(link),
        .i_pred(pred),
        .o_exec(exec)
    );

    // stores write and loads read at the edge the result register loads
    teu_dmem u_dmem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (commit && exec.mem_we),
        .i_re   (commit && exec.is_load),
        .i_addr (exec.daddr),
        .i_wdata(exec.store_data),
        .o_rdata(ld_data),
        .o_busy (dmem_busy)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wb_pend <= 1'b0;
            r_pc      <= '0;
        end else begin
            if (s_accept) begin
                r_ex_vld <= 1'b1;
            end else if (commit) begin
                r_ex_vld <= 1'b0;
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            r_wb_pend <= commit && exec.reg_we;
            if (cfg_accept) begin
                r_pc <= i_cfg_data;
            end else if (commit) begin
                r_pc <= exec.next_address;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ex_func <= in_func;
            r_ex_word <= i_s_axis_tdata;
        end
        if (commit) begin
            r_out.next_address  <= exec.next_address;
            r_out.reg_we        <= exec.reg_we;
            r_out.target        <= exec.target;
            r_out.value         <= exec.value;
            r_out.mem_we        <= exec.mem_we;
            r_out.store_address <= exec.store_address;
            r_out.is_load       <= exec.is_load;
            r_wb_idx            <= exec.target;
            r_wb_val            <= exec.value;
            r_wb_load           <= exec.is_load;
        end
    end

    // the data memory output holds the loaded word until the beat is taken
    assign out_value = r_out.is_load ? ld_data : r_out.value;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'b0000, r_out.store_address, out_value, r_out.target,
                              r_out.next_address};
    assign o_m_axis_tuser  = {r_out.mem_we, r_out.reg_we};

    // a register result is written back in the cycle after it is produced
    a_wb_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && exec.reg_we) |=> (rf_wr.we && (rf_wr.idx == $past(exec.target))))
        else $error("register write back missing after result");

    // the program counter moves only on an executed instruction or a start_address write
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!commit && !cfg_accept) |=> $stable(r_pc))
        else $error("program counter changed without cause");

    // add and movi, as straight-line instructions, advance by one word
    a_pc_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && ((r_ex_func == FN_ADD) || (r_ex_func == FN_MOVI)))
        |=> (r_out.next_address == $past(r_pc) + INSN_BYTES))
        else $error("sequential next address wrong");

    // a result never both loads and stores
    a_ld_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.mem_we && r_out.is_load))
        else $error("load and store in one result");

endmodule
